/* hw/rtl/word_bitmap_heap_allocator_macros.svh */
// assertion helpers for the heap allocator
`ifndef WORD_BITMAP_HEAP_ALLOCATOR_MACROS_SVH
`define WORD_BITMAP_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define WBHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define WBHA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WBHA_ASSERT(lbl, prop, msg)
`define WBHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/wbha_pkg.sv */
package wbha_pkg;

   localparam int MEM_WORDS   = 1024;
   localparam int SLOTS       = 1024;
   localparam int ENTRIES     = 1024;
   localparam int TABLE_LIMIT = 1000;

   localparam int ADDR_W   = 10;
   localparam int SLOT_W   = 10;
   localparam int IDX_W    = 10;
   localparam int TOP_W    = 11;
   localparam int USED_W   = 11;
   localparam int CNT_W    = 13;
   localparam int TYPE_W   = 2;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int HEAP_W   = 11;
   localparam int ENT_W    = ADDR_W + TYPE_W + CNT_W;

   localparam logic [TOP_W-1:0]  TOP_MAX    = TOP_W'(MEM_WORDS);
   localparam logic [USED_W-1:0] USED_LIMIT = USED_W'(TABLE_LIMIT);

   localparam logic [2:0] ELEM_BYTES [4] = '{3'd1, 3'd1, 3'd3, 3'd4};

   localparam logic [MODE_W-1:0] MODE_ALLOC_SCALAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC_ARRAY  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FREE         = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COMPACT      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOKUP       = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_TAKEN      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_MEM     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_BAD_MODE   = 3'd5;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SLOT, ST_DISP, ST_ENT, ST_RUN, ST_ABIND,
      ST_SC_RD, ST_SC_CK, ST_C_IRD, ST_C_ICK, ST_C_JRD, ST_C_JCK,
      ST_C_OWN, ST_C_ENT, ST_C_CLR, ST_C_SET, ST_C_FIN, ST_RETRY, ST_DONE
   } state_type;

   typedef enum logic [1:0] {MA_W, MA_I, MA_J} mark_addr_type;
   typedef enum logic [2:0] {MW_NONE, MW_RUN, MW_SCAN, MW_MV_CLR, MW_MV_SET} mark_wr_type;
   typedef enum logic [1:0] {OW_NONE, OW_SCAN, OW_ARR, OW_MV} own_wr_type;
   typedef enum logic [1:0] {SW_NONE, SW_BIND, SW_FREE} slot_wr_type;
   typedef enum logic [1:0] {EW_NONE, EW_SCAN, EW_ARR, EW_MV} ent_wr_type;
   typedef enum logic {EA_SLOT, EA_OWNER} ent_addr_type;
   typedef enum logic [2:0] {RL_NONE, RL_CODE, RL_ENT, RL_SCAN, RL_ARR} res_type;
   typedef enum logic [1:0] {RS_NONE, RS_FREE, RS_ARR} run_type;

   typedef struct packed {
      logic                clr_step;
      logic                latch_req;
      mark_addr_type       mark_addr;
      mark_wr_type         mark_wr;
      own_wr_type          own_wr;
      slot_wr_type         slot_wr;
      ent_wr_type          ent_wr;
      ent_addr_type        ent_addr;
      logic                w_clr;
      logic                w_inc;
      logic                i_init;
      logic                i_inc;
      logic                j_from_i;
      logic                j_inc;
      logic                mv_own;
      logic                mv_ent;
      logic                k_inc;
      run_type             run_start;
      logic                run_step;
      logic                top_scan;
      logic                top_arr;
      logic                top_cmp;
      res_type             res;
      logic [STATUS_W-1:0] res_code;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              clr_last;
      logic              table_full;
      logic              slot_valid;
      logic              mark_bit;
      logic              w_end;
      logic              i_end;
      logic              j_end;
      logic              mv_done;
      logic              run_done;
      logic              arr_fits;
   } stat_type;

   // words needed for count elements of the given type, rounded up
   function automatic logic [CNT_W-1:0] words_of(input logic [TYPE_W-1:0] etype,
                                                 input logic [CNT_W-1:0] count);
      logic [15:0] bytes;
      logic [15:0] sum;
      bytes = 16'(count) * 16'(ELEM_BYTES[etype]);
      sum   = bytes + 16'd3;
      return sum[14:2];
   endfunction

endpackage

/* hw/rtl/wbha_ctrl.sv */
`include "word_bitmap_heap_allocator_macros.svh"

module wbha_ctrl import wbha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      retry_ff, retry_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         retry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      retry_in  = retry_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_SLOT;
            end
         end
         ST_SLOT: state_in = ST_DISP;
         ST_DISP: begin
            cmd.ent_addr = EA_SLOT;
            if (st.mode == MODE_ALLOC_SCALAR || st.mode == MODE_ALLOC_ARRAY) begin
               if (st.table_full) begin
                  cmd.res      = RL_CODE;
                  cmd.res_code = STAT_TABLE_FULL;
                  state_in     = ST_DONE;
               end else if (st.slot_valid) begin
                  state_in = ST_ENT;
               end else if (st.mode == MODE_ALLOC_SCALAR) begin
                  cmd.w_clr = 1'b1;
                  state_in  = ST_SC_RD;
               end else if (st.arr_fits) begin
                  cmd.run_start = RS_ARR;
                  state_in      = ST_RUN;
               end else begin
                  cmd.i_init = 1'b1;
                  retry_in   = 1'b1;
                  state_in   = ST_C_IRD;
               end
            end else if (st.mode == MODE_FREE || st.mode == MODE_LOOKUP) begin
               if (!st.slot_valid) begin
                  cmd.res      = RL_CODE;
                  cmd.res_code = STAT_EMPTY;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_ENT;
               end
            end else if (st.mode == MODE_COMPACT) begin
               cmd.i_init = 1'b1;
               retry_in   = 1'b0;
               state_in   = ST_C_IRD;
            end else begin
               cmd.res      = RL_CODE;
               cmd.res_code = STAT_BAD_MODE;
               state_in     = ST_DONE;
            end
         end
         ST_ENT: begin
            cmd.res      = RL_ENT;
            cmd.res_code = (st.mode == MODE_ALLOC_SCALAR || st.mode == MODE_ALLOC_ARRAY)
                           ? STAT_TAKEN : STAT_OK;
            if (st.mode == MODE_FREE) begin
               cmd.run_start = RS_FREE;
               cmd.slot_wr   = SW_FREE;
               state_in      = ST_RUN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RUN: begin
            if (st.run_done) begin
               state_in = (st.mode == MODE_ALLOC_ARRAY) ? ST_ABIND : ST_DONE;
            end else begin
               cmd.mark_wr  = MW_RUN;
               cmd.run_step = 1'b1;
            end
         end
         ST_ABIND: begin
            cmd.own_wr  = OW_ARR;
            cmd.slot_wr = SW_BIND;
            cmd.ent_wr  = EW_ARR;
            cmd.top_arr = 1'b1;
            cmd.res     = RL_ARR;
            state_in    = ST_DONE;
         end
         ST_SC_RD: begin
            cmd.mark_addr = MA_W;
            if (st.w_end) begin
               cmd.res      = RL_CODE;
               cmd.res_code = STAT_NO_MEM;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_SC_CK;
            end
         end
         ST_SC_CK: begin
            if (st.mark_bit) begin
               cmd.w_inc = 1'b1;
               state_in  = ST_SC_RD;
            end else begin
               cmd.mark_wr  = MW_SCAN;
               cmd.own_wr   = OW_SCAN;
               cmd.slot_wr  = SW_BIND;
               cmd.ent_wr   = EW_SCAN;
               cmd.top_scan = 1'b1;
               cmd.res      = RL_SCAN;
               state_in     = ST_DONE;
            end
         end
         ST_C_IRD, ST_C_JRD: begin
            cmd.mark_addr = (state_ff == ST_C_IRD) ? MA_I : MA_J;
            if ((state_ff == ST_C_IRD) ? st.i_end : st.j_end) begin
               cmd.top_cmp = 1'b1;
               if (retry_ff) begin
                  state_in = ST_RETRY;
               end else begin
                  cmd.res      = RL_CODE;
                  cmd.res_code = STAT_OK;
                  state_in     = ST_DONE;
               end
            end else begin
               state_in = (state_ff == ST_C_IRD) ? ST_C_ICK : ST_C_JCK;
            end
         end
         ST_C_ICK: begin
            if (st.mark_bit) begin
               cmd.i_inc = 1'b1;
               state_in  = ST_C_IRD;
            end else begin
               cmd.j_from_i = 1'b1;
               state_in     = ST_C_JRD;
            end
         end
         ST_C_JCK: begin
            if (!st.mark_bit) begin
               cmd.j_inc = 1'b1;
               state_in  = ST_C_JRD;
            end else begin
               state_in = ST_C_OWN;
            end
         end
         ST_C_OWN: begin
            cmd.ent_addr = EA_OWNER;
            cmd.mv_own   = 1'b1;
            state_in     = ST_C_ENT;
         end
         ST_C_ENT: begin
            cmd.mv_ent = 1'b1;
            state_in   = ST_C_CLR;
         end
         // clear the old word before setting the new one, overlapping runs rely on it
         ST_C_CLR: begin
            if (st.mv_done) begin
               state_in = ST_C_FIN;
            end else begin
               cmd.mark_wr = MW_MV_CLR;
               state_in    = ST_C_SET;
            end
         end
         ST_C_SET: begin
            cmd.mark_wr = MW_MV_SET;
            cmd.k_inc   = 1'b1;
            state_in    = ST_C_CLR;
         end
         ST_C_FIN: begin
            cmd.ent_wr = EW_MV;
            cmd.own_wr = OW_MV;
            state_in   = ST_C_IRD;
         end
         ST_RETRY: begin
            if (st.arr_fits) begin
               cmd.run_start = RS_ARR;
               state_in      = ST_RUN;
            end else begin
               cmd.res      = RL_CODE;
               cmd.res_code = STAT_NO_MEM;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   `WBHA_ASSERT(a_accept_to_slot, req_valid && req_ready |=> state_ff == ST_SLOT, "accept did not start slot read")
   `WBHA_ASSERT(a_load_free, cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `WBHA_ASSERT(a_clear_once, state_ff != ST_CLEAR |=> state_ff != ST_CLEAR, "clearing pass reentered")

endmodule

/* hw/rtl/wbha_dp.sv */
`include "word_bitmap_heap_allocator_macros.svh"

module wbha_dp import wbha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            st,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TYPE_W-1:0]   req_elem_type,
   input  logic [CNT_W-1:0]    req_elem_count,
   input  logic                csr_valid,
   input  logic [HEAP_W-1:0]   csr_heap_words,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_entry_index,
   output logic [ADDR_W-1:0]   rsp_base_word,
   output logic [TYPE_W-1:0]   rsp_entry_type,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [TOP_W-1:0]    rsp_top_word
);

   // storage
   logic              marks_mem [MEM_WORDS];
   logic [IDX_W:0]    slot_mem  [SLOTS];
   logic [ENT_W-1:0]  ent_mem   [ENTRIES];
   logic [IDX_W-1:0]  own_mem   [MEM_WORDS];

   logic              mark_rd_ff;
   logic [IDX_W:0]    slot_rd_ff;
   logic [ENT_W-1:0]  ent_rd_ff;
   logic [IDX_W-1:0]  own_rd_ff;

   // control registers
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [HEAP_W-1:0] heap_ff, heap_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [USED_W-1:0] used_ff, used_in;

   // request and working registers
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TOP_W-1:0]  w_ff, w_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  mv_e_ff, mv_e_in;
   logic [TYPE_W-1:0] mv_type_ff, mv_type_in;
   logic [CNT_W-1:0]  mv_count_ff, mv_count_in, mv_len_ff, mv_len_in;
   logic [TOP_W-1:0]  run_a_ff, run_a_in;
   logic [CNT_W-1:0]  run_rem_ff, run_rem_in;
   logic              run_val_ff, run_val_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_entry_ff, res_entry_in;
   logic [ADDR_W-1:0]   res_base_ff, res_base_in;
   logic [TYPE_W-1:0]   res_type_ff, res_type_in;
   logic [CNT_W-1:0]    res_count_ff, res_count_in;

   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [IDX_W-1:0]    out_entry_ff, out_entry_in;
   logic [ADDR_W-1:0]   out_base_ff, out_base_in;
   logic [TYPE_W-1:0]   out_type_ff, out_type_in;
   logic [CNT_W-1:0]    out_count_ff, out_count_in;
   logic [TOP_W-1:0]    out_top_ff, out_top_in;

   // derived values
   logic [TOP_W-1:0]  heap_n;
   logic [TOP_W-1:0]  avail;
   logic [CNT_W-1:0]  req_len;
   logic [CNT_W-1:0]  ent_len;
   logic [ADDR_W-1:0] ent_base;
   logic [TYPE_W-1:0] ent_type;
   logic [CNT_W-1:0]  ent_count;
   logic [13:0]       j_sum, i_sum;
   logic [TOP_W-1:0]  w_next;

   logic [ADDR_W-1:0] mark_ra, mark_wa;
   logic              mark_we, mark_wd;
   logic [IDX_W-1:0]  ent_ra, ent_wa;
   logic              ent_we;
   logic [ENT_W-1:0]  ent_wd;
   logic              slot_we;
   logic [IDX_W:0]    slot_wd;
   logic [SLOT_W-1:0] slot_wa;
   logic              own_we;
   logic [ADDR_W-1:0] own_wa;
   logic [IDX_W-1:0]  own_wd;

   assign heap_n    = (heap_ff > TOP_MAX) ? TOP_MAX : heap_ff;
   assign avail     = (heap_n > top_ff) ? heap_n - top_ff : '0;
   assign req_len   = words_of(type_ff, count_ff);
   assign ent_base  = ent_rd_ff[ENT_W-1 -: ADDR_W];
   assign ent_type  = ent_rd_ff[CNT_W +: TYPE_W];
   assign ent_count = ent_rd_ff[CNT_W-1:0];
   assign ent_len   = words_of(ent_type, ent_count);
   assign j_sum     = {3'b000, j_ff} + {1'b0, k_ff};
   assign i_sum     = {3'b000, i_ff} + {1'b0, k_ff};
   assign w_next    = w_ff + 1'b1;

   assign st.mode       = mode_ff;
   assign st.clr_last   = (clr_ff == ADDR_W'(MEM_WORDS - 1));
   assign st.table_full = (used_ff >= USED_LIMIT);
   assign st.slot_valid = slot_rd_ff[IDX_W];
   assign st.mark_bit   = mark_rd_ff;
   assign st.w_end      = (w_ff >= heap_n);
   assign st.i_end      = (i_ff >= heap_n);
   assign st.j_end      = (j_ff >= heap_n);
   assign st.mv_done    = (k_ff >= mv_len_ff);
   assign st.run_done   = (run_rem_ff == '0) || run_a_ff[ADDR_W];
   assign st.arr_fits   = ({2'b00, avail} >= req_len);

   // memory addressing
   always_comb begin
      unique case (cmd.mark_addr)
         MA_W:    mark_ra = w_ff[ADDR_W-1:0];
         MA_I:    mark_ra = i_ff[ADDR_W-1:0];
         MA_J:    mark_ra = j_ff[ADDR_W-1:0];
         default: mark_ra = w_ff[ADDR_W-1:0];
      endcase
      ent_ra = (cmd.ent_addr == EA_OWNER) ? own_rd_ff : slot_rd_ff[IDX_W-1:0];

      mark_we = 1'b0;
      mark_wa = w_ff[ADDR_W-1:0];
      mark_wd = 1'b1;
      own_we  = 1'b0;
      own_wa  = w_ff[ADDR_W-1:0];
      own_wd  = used_ff[IDX_W-1:0];
      slot_we = 1'b0;
      slot_wa = slot_ff;
      slot_wd = '0;
      ent_we  = 1'b0;
      ent_wa  = used_ff[IDX_W-1:0];
      ent_wd  = {w_ff[ADDR_W-1:0], type_ff, CNT_W'(1)};

      if (cmd.clr_step) begin
         mark_we = 1'b1;
         mark_wa = clr_ff;
         mark_wd = (clr_ff == '0);
         slot_we = 1'b1;
         slot_wa = clr_ff;
         slot_wd = (clr_ff == '0) ? {1'b1, IDX_W'(0)} : '0;
         ent_we  = 1'b1;
         ent_wa  = clr_ff;
         ent_wd  = (clr_ff == '0) ? {ADDR_W'(0), TYPE_W'(3), CNT_W'(1)} : '0;
      end else begin
         unique case (cmd.mark_wr)
            MW_NONE: mark_we = 1'b0;
            MW_RUN: begin
               mark_we = 1'b1;
               mark_wa = run_a_ff[ADDR_W-1:0];
               mark_wd = run_val_ff;
            end
            MW_SCAN: mark_we = 1'b1;
            MW_MV_CLR: begin
               mark_we = (j_sum < 14'(MEM_WORDS));
               mark_wa = j_sum[ADDR_W-1:0];
               mark_wd = 1'b0;
            end
            MW_MV_SET: begin
               mark_we = (i_sum < 14'(MEM_WORDS));
               mark_wa = i_sum[ADDR_W-1:0];
            end
            default: mark_we = 1'b0;
         endcase

         unique case (cmd.own_wr)
            OW_NONE: own_we = 1'b0;
            OW_SCAN: own_we = 1'b1;
            OW_ARR: begin
               own_we = (req_len != '0) && !top_ff[ADDR_W];
               own_wa = top_ff[ADDR_W-1:0];
            end
            OW_MV: begin
               own_we = 1'b1;
               own_wa = i_ff[ADDR_W-1:0];
               own_wd = mv_e_ff;
            end
            default: own_we = 1'b0;
         endcase

         unique case (cmd.slot_wr)
            SW_NONE: slot_we = 1'b0;
            SW_BIND: begin
               slot_we = 1'b1;
               slot_wd = {1'b1, used_ff[IDX_W-1:0]};
            end
            SW_FREE: slot_we = 1'b1;
            default: slot_we = 1'b0;
         endcase

         unique case (cmd.ent_wr)
            EW_NONE: ent_we = 1'b0;
            EW_SCAN: ent_we = 1'b1;
            EW_ARR: begin
               ent_we = 1'b1;
               ent_wd = {top_ff[ADDR_W-1:0], type_ff, count_ff};
            end
            EW_MV: begin
               ent_we = 1'b1;
               ent_wa = mv_e_ff;
               ent_wd = {i_ff[ADDR_W-1:0], mv_type_ff, mv_count_ff};
            end
            default: ent_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) marks_mem[mark_wa] <= mark_wd;
      mark_rd_ff <= marks_mem[mark_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      ent_rd_ff <= ent_mem[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (own_we) own_mem[own_wa] <= own_wd;
      own_rd_ff <= own_mem[j_ff[ADDR_W-1:0]];
   end

   // next values
   always_comb begin
      clr_in  = cmd.clr_step ? clr_ff + 1'b1 : clr_ff;
      heap_in = csr_valid ? csr_heap_words : heap_ff;
      used_in = (cmd.slot_wr == SW_BIND) ? used_ff + 1'b1 : used_ff;

      top_in = top_ff;
      if (cmd.top_scan && (top_ff < w_next)) top_in = w_next;
      if (cmd.top_arr) top_in = top_ff + req_len[TOP_W-1:0];
      if (cmd.top_cmp) top_in = i_ff;

      mode_in  = cmd.latch_req ? req_mode : mode_ff;
      slot_in  = cmd.latch_req ? req_slot : slot_ff;
      type_in  = cmd.latch_req ? req_elem_type : type_ff;
      count_in = cmd.latch_req ? req_elem_count : count_ff;

      w_in = cmd.w_clr ? '0 : (cmd.w_inc ? w_next : w_ff);
      i_in = cmd.i_init ? TOP_W'(1) : (cmd.i_inc ? i_ff + 1'b1 : i_ff);
      j_in = cmd.j_from_i ? i_ff : (cmd.j_inc ? j_ff + 1'b1 : j_ff);
      k_in = cmd.mv_ent ? '0 : (cmd.k_inc ? k_ff + 1'b1 : k_ff);

      mv_e_in     = cmd.mv_own ? own_rd_ff : mv_e_ff;
      mv_type_in  = cmd.mv_ent ? ent_type : mv_type_ff;
      mv_count_in = cmd.mv_ent ? ent_count : mv_count_ff;
      // a block of no words still moves one word
      mv_len_in   = cmd.mv_ent ? ((ent_len == '0) ? CNT_W'(1) : ent_len) : mv_len_ff;

      run_a_in   = run_a_ff;
      run_rem_in = run_rem_ff;
      run_val_in = run_val_ff;
      unique case (cmd.run_start)
         RS_NONE: begin
            if (cmd.run_step) begin
               run_a_in   = run_a_ff + 1'b1;
               run_rem_in = run_rem_ff - 1'b1;
            end
         end
         RS_FREE: begin
            run_a_in   = {1'b0, ent_base};
            run_rem_in = ent_len;
            run_val_in = 1'b0;
         end
         RS_ARR: begin
            run_a_in   = top_ff;
            run_rem_in = req_len;
            run_val_in = 1'b1;
         end
         default: run_val_in = run_val_ff;
      endcase

      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      res_base_in   = res_base_ff;
      res_type_in   = res_type_ff;
      res_count_in  = res_count_ff;
      unique case (cmd.res)
         RL_NONE: res_status_in = res_status_ff;
         RL_CODE: begin
            res_status_in = cmd.res_code;
            res_entry_in  = '0;
            res_base_in   = '0;
            res_type_in   = '0;
            res_count_in  = '0;
         end
         RL_ENT: begin
            res_status_in = cmd.res_code;
            res_entry_in  = slot_rd_ff[IDX_W-1:0];
            res_base_in   = ent_base;
            res_type_in   = ent_type;
            res_count_in  = ent_count;
         end
         RL_SCAN: begin
            res_status_in = STAT_OK;
            res_entry_in  = used_ff[IDX_W-1:0];
            res_base_in   = w_ff[ADDR_W-1:0];
            res_type_in   = type_ff;
            res_count_in  = CNT_W'(1);
         end
         RL_ARR: begin
            res_status_in = STAT_OK;
            res_entry_in  = used_ff[IDX_W-1:0];
            res_base_in   = top_ff[ADDR_W-1:0];
            res_type_in   = type_ff;
            res_count_in  = count_ff;
         end
         default: res_status_in = res_status_ff;
      endcase

      out_status_in = cmd.rsp_load ? res_status_ff : out_status_ff;
      out_entry_in  = cmd.rsp_load ? res_entry_ff : out_entry_ff;
      out_base_in   = cmd.rsp_load ? res_base_ff : out_base_ff;
      out_type_in   = cmd.rsp_load ? res_type_ff : out_type_ff;
      out_count_in  = cmd.rsp_load ? res_count_ff : out_count_ff;
      out_top_in    = cmd.rsp_load ? top_ff : out_top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         heap_ff <= HEAP_W'(MEM_WORDS);
         top_ff  <= TOP_W'(1);
         used_ff <= USED_W'(1);
      end else begin
         clr_ff  <= clr_in;
         heap_ff <= heap_in;
         top_ff  <= top_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      type_ff       <= type_in;
      count_ff      <= count_in;
      w_ff          <= w_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      mv_e_ff       <= mv_e_in;
      mv_type_ff    <= mv_type_in;
      mv_count_ff   <= mv_count_in;
      mv_len_ff     <= mv_len_in;
      run_a_ff      <= run_a_in;
      run_rem_ff    <= run_rem_in;
      run_val_ff    <= run_val_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      res_base_ff   <= res_base_in;
      res_type_ff   <= res_type_in;
      res_count_ff  <= res_count_in;
      out_status_ff <= out_status_in;
      out_entry_ff  <= out_entry_in;
      out_base_ff   <= out_base_in;
      out_type_ff   <= out_type_in;
      out_count_ff  <= out_count_in;
      out_top_ff    <= out_top_in;
   end

   assign rsp_status      = out_status_ff;
   assign rsp_entry_index = out_entry_ff;
   assign rsp_base_word   = out_base_ff;
   assign rsp_entry_type  = out_type_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_top_word    = out_top_ff;

   `WBHA_ASSERT(a_top_range, top_ff <= TOP_MAX, "top pointer past heap")
   `WBHA_ASSERT(a_used_range, used_ff <= USED_LIMIT, "entry count past table limit")
   `WBHA_ASSERT(a_run_in_heap, cmd.mark_wr == MW_RUN |-> !run_a_ff[ADDR_W], "mark run past heap end")

endmodule

/* hw/rtl/word_bitmap_heap_allocator.sv */
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    mode, slot, elem_type, elem_count
// rsp      out        rsp_valid/rsp_ready    status, entry_index, base_word, entry_type,
//                                            entry_count, top_word
// csr      in         csr_valid/csr_ready    heap_words
//
// lookup reads the slot and then its entry; empty slots and errors end at dispatch
// scalar alloc walks the bitmap one word at a time through its single-port read
// free and array alloc mark each block word; compaction walks the bitmap words
//   and moves each block found, clearing and then setting the mark of each word
// after reset a clearing pass over all 1024 words runs with req_ready low
// one request can be accepted while the previous result waits in the output register
module word_bitmap_heap_allocator import wbha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TYPE_W-1:0]   req_elem_type,
   input  logic [CNT_W-1:0]    req_elem_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_entry_index,
   output logic [ADDR_W-1:0]   rsp_base_word,
   output logic [TYPE_W-1:0]   rsp_entry_type,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [TOP_W-1:0]    rsp_top_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [HEAP_W-1:0]   csr_heap_words
);

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   wbha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   wbha_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_mode        (req_mode),
      .req_slot        (req_slot),
      .req_elem_type   (req_elem_type),
      .req_elem_count  (req_elem_count),
      .csr_valid       (csr_valid),
      .csr_heap_words  (csr_heap_words),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_base_word   (rsp_base_word),
      .rsp_entry_type  (rsp_entry_type),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_word    (rsp_top_word)
   );

endmodule
